### sv/spmq_pkg.sv
// package for the strict priority multi-level queue
// holds request kinds, result status codes, defaults and controller/datapath structs
// no dependencies

package spmq_pkg;

	// default sizing
	localparam int unsigned LEVELS_DEF       = 3;
	localparam int unsigned LEVEL_DEPTH_DEF  = 16;
	localparam int unsigned PAYLOAD_BITS_DEF = 16;

	// fixed field widths of the stream ports
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned LEVEL_W   = 2;
	localparam int unsigned PAYLOAD_W = 16;
	localparam int unsigned STATUS_W  = 3;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DEQUEUED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic rd;
		logic commit;
	} spmq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic deq;
		logic ign;
		logic out_free;
	} spmq_sts_t;

endpackage

### sv/strict_priority_multi_queue.sv
// Strict priority multi-level queue: one FIFO per priority level in a shared item memory,
// the highest non-empty level is always served first, arrival order within a level.
// Requests arrive on the slave stream with the kind in tuser: enqueue, dequeue or stop.
// Every enqueue, dequeue and stop gives one result on the master stream with its status in
// tuser; an unused kind is dropped with no result. One request is worked on at a time:
// an enqueue or stop is written to the result register from the held request, a dequeue
// after the registered read of the item memory. The next request is taken as soon as
// the current one has been written to the result register, so a result may wait there
// while the following request is held. A result still waiting in the result register
// stalls the commit of the held request until m_tready frees the register.
// After a stop, enqueues are refused but queued items can still be dequeued.
// An enqueue to a full level is dropped and flagged.
// Depends on spmq_pkg, spmq_ctrl and spmq_dp.

module strict_priority_multi_queue #(
	parameter int unsigned LEVELS       = spmq_pkg::LEVELS_DEF,
	parameter int unsigned LEVEL_DEPTH  = spmq_pkg::LEVEL_DEPTH_DEF,
	parameter int unsigned PAYLOAD_BITS = spmq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // level [1:0], payload [17:2], zero [23:18]
	input  logic [1:0]  s_tuser,   // kind [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_payload [15:0], out_level [17:16],
	                               // now_empty [18], drained [19], zero [23:20]
	output logic [2:0]  m_tuser    // status [2:0]
);

	spmq_pkg::spmq_cmd_t cmd;
	spmq_pkg::spmq_sts_t sts;

	logic [spmq_pkg::PAYLOAD_W-1:0] out_payload;
	logic [spmq_pkg::LEVEL_W-1:0]   out_level;
	logic                           now_empty;
	logic                           drained;

	// request sequencing
	spmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// queue storage and result
	spmq_dp #(
		.LEVELS       (LEVELS),
		.LEVEL_DEPTH  (LEVEL_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_kind     (s_tuser),
		.in_level    (s_tdata[1:0]),
		.in_payload  (s_tdata[17:2]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.status      (m_tuser),
		.out_payload (out_payload),
		.out_level   (out_level),
		.now_empty   (now_empty),
		.drained     (drained)
	);

	// pack the result
	assign m_tdata = {4'd0, drained, now_empty, out_level, out_payload};

endmodule

### sv/spmq_ctrl.sv
// controller of the strict priority multi-level queue
// sequences capture, item memory read and commit of one request at a time
// depends on spmq_pkg

module spmq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  spmq_pkg::spmq_sts_t sts,
	output spmq_pkg::spmq_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		RDATA
	} state_t;

	state_t state_q;

	// ready whenever no request is held
	assign s_tready = (state_q == IDLE);

	// commands from state and datapath status
	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				cmd.capture = s_tvalid;
			end
			EXEC: begin
				cmd.rd     = sts.deq;
				cmd.commit = !sts.ign && !sts.deq && sts.out_free;
			end
			RDATA: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) state_q <= EXEC;
				end
				EXEC: begin
					priority if (sts.ign) begin
						state_q <= IDLE;
					end else if (sts.deq) begin
						state_q <= RDATA;
					end else if (sts.out_free) begin
						state_q <= IDLE;
					end
				end
				RDATA: begin
					if (sts.out_free) state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

### sv/spmq_dp.sv
// datapath of the strict priority multi-level queue
// item memory, per level pointers and counts, top level encoder, result register
// depends on spmq_pkg

module spmq_dp #(
	parameter int unsigned LEVELS       = spmq_pkg::LEVELS_DEF,
	parameter int unsigned LEVEL_DEPTH  = spmq_pkg::LEVEL_DEPTH_DEF,
	parameter int unsigned PAYLOAD_BITS = spmq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spmq_pkg::spmq_cmd_t               cmd,
	output spmq_pkg::spmq_sts_t               sts,
	input  logic [spmq_pkg::KIND_W-1:0]       in_kind,
	input  logic [spmq_pkg::LEVEL_W-1:0]      in_level,
	input  logic [spmq_pkg::PAYLOAD_W-1:0]    in_payload,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [spmq_pkg::STATUS_W-1:0]     status,
	output logic [spmq_pkg::PAYLOAD_W-1:0]    out_payload,
	output logic [spmq_pkg::LEVEL_W-1:0]      out_level,
	output logic                              now_empty,
	output logic                              drained
);

	localparam int unsigned LIW      = $clog2(LEVELS);
	localparam int unsigned PW       = $clog2(LEVEL_DEPTH);
	localparam int unsigned CW       = $clog2(LEVEL_DEPTH + 1);
	localparam int unsigned MEM_D    = LEVELS * LEVEL_DEPTH;
	localparam int unsigned AW       = $clog2(MEM_D);
	localparam int unsigned SW       = (PAYLOAD_BITS < spmq_pkg::PAYLOAD_W) ?
	                                   PAYLOAD_BITS : spmq_pkg::PAYLOAD_W;

	// held request
	logic [spmq_pkg::KIND_W-1:0] kind_q;
	logic [LIW-1:0]              lvl_q;
	logic [SW-1:0]               pay_q;

	// queue state
	logic [PW-1:0]  head_q [LEVELS];
	logic [PW-1:0]  tail_q [LEVELS];
	logic [CW-1:0]  cnt_q  [LEVELS];
	logic [LIW-1:0] top_q;
	logic           any_q;
	logic           stop_q;

	// item memory and registered read
	logic [SW-1:0] mem [MEM_D];
	logic [SW-1:0] rd_q;

	// result register
	logic                              ovalid_q;
	logic [spmq_pkg::STATUS_W-1:0]     status_q;
	logic [spmq_pkg::PAYLOAD_W-1:0]    opay_q;
	logic [spmq_pkg::LEVEL_W-1:0]      olvl_q;
	logic                              empty_q;
	logic                              drained_q;

	logic [LIW-1:0] lvl_sat;
	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  rd_addr;
	logic           enq_ok;
	logic           deq_ok;
	logic [LEVELS-1:0] nz;
	logic [LIW-1:0] top_n;
	logic           any_n;
	logic           stop_n;
	logic [spmq_pkg::STATUS_W-1:0] status_n;

	// saturate an out of range level to the highest one
	always_comb begin
		if (32'(in_level) >= LEVELS) begin
			lvl_sat = LIW'(LEVELS - 1);
		end else begin
			lvl_sat = LIW'(in_level);
		end
	end

	// status to controller
	assign sts.deq      = (kind_q == spmq_pkg::KIND_DEQ);
	assign sts.ign      = (kind_q != spmq_pkg::KIND_ENQ) && (kind_q != spmq_pkg::KIND_DEQ) &&
	                      (kind_q != spmq_pkg::KIND_STOP);
	assign sts.out_free = !ovalid_q || m_tready;

	// memory addresses
	assign wr_addr = AW'(int'(lvl_q) * LEVEL_DEPTH + int'(tail_q[lvl_q]));
	assign rd_addr = AW'(int'(top_q) * LEVEL_DEPTH + int'(head_q[top_q]));

	assign enq_ok = (kind_q == spmq_pkg::KIND_ENQ) && !stop_q &&
	                (cnt_q[lvl_q] != CW'(LEVEL_DEPTH));
	assign deq_ok = (kind_q == spmq_pkg::KIND_DEQ) && any_q;

	// levels left non-empty after a dequeue from the top level
	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			if (LIW'(i) == top_q) begin
				nz[i] = (cnt_q[i] > CW'(1));
			end else begin
				nz[i] = (cnt_q[i] != '0);
			end
		end
	end

	// next top level, any flag, stop flag and status
	always_comb begin
		top_n    = top_q;
		any_n    = any_q;
		stop_n   = stop_q;
		status_n = spmq_pkg::ST_STOPPED;
		unique case (kind_q)
			spmq_pkg::KIND_ENQ: begin
				priority if (stop_q) begin
					status_n = spmq_pkg::ST_REFUSED;
				end else if (!enq_ok) begin
					status_n = spmq_pkg::ST_FULL;
				end else begin
					status_n = spmq_pkg::ST_ACCEPTED;
					any_n    = 1'b1;
					if (!any_q || (lvl_q > top_q)) top_n = lvl_q;
				end
			end
			spmq_pkg::KIND_DEQ: begin
				if (!any_q) begin
					status_n = spmq_pkg::ST_EMPTY;
				end else begin
					status_n = spmq_pkg::ST_DEQUEUED;
					top_n    = '0;
					for (int i = 0; i < LEVELS; i++) begin
						if (nz[i]) top_n = LIW'(i);
					end
					any_n = |nz;
				end
			end
			spmq_pkg::KIND_STOP: begin
				stop_n   = 1'b1;
				status_n = spmq_pkg::ST_STOPPED;
			end
			default: begin
				status_n = spmq_pkg::ST_STOPPED;
			end
		endcase
	end

	// request hold, memory and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			lvl_q  <= lvl_sat;
			pay_q  <= SW'(in_payload);
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.commit && enq_ok) begin
			mem[wr_addr] <= pay_q;
		end
		if (cmd.commit) begin
			status_q  <= status_n;
			opay_q    <= deq_ok ? spmq_pkg::PAYLOAD_W'(rd_q) : '0;
			olvl_q    <= deq_ok ? spmq_pkg::LEVEL_W'(top_q) : '0;
			empty_q   <= !any_n;
			drained_q <= stop_n && !any_n;
		end
	end

	// queue state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			top_q    <= '0;
			any_q    <= 1'b0;
			stop_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				top_q  <= top_n;
				any_q  <= any_n;
				stop_q <= stop_n;
				if (enq_ok) begin
					tail_q[lvl_q] <= (tail_q[lvl_q] == PW'(LEVEL_DEPTH - 1)) ?
					                 '0 : tail_q[lvl_q] + 1'b1;
					cnt_q[lvl_q]  <= cnt_q[lvl_q] + 1'b1;
				end
				if (deq_ok) begin
					head_q[top_q] <= (head_q[top_q] == PW'(LEVEL_DEPTH - 1)) ?
					                 '0 : head_q[top_q] + 1'b1;
					cnt_q[top_q]  <= cnt_q[top_q] - 1'b1;
				end
			end
			if (cmd.commit) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid    = ovalid_q;
	assign status      = status_q;
	assign out_payload = opay_q;
	assign out_level   = olvl_q;
	assign now_empty   = empty_q;
	assign drained     = drained_q;

endmodule
